// ===== hdl/pct_pkg.sv =====
// Package for the path completion tracker: operation, status and update codes,
// default sizes and the command struct of the path counter unit.
// No dependencies.
package pct_pkg;

  localparam int EDGES_DEF = 256;
  localparam int PATHS_DEF = 32;
  localparam int PIDX_W    = 6;

  localparam logic [1:0] OP_LINK  = 2'd0;
  localparam logic [1:0] OP_ON    = 2'd1;
  localparam logic [1:0] OP_OFF   = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ALREADY_ON = 2'd1;
  localparam logic [1:0] ST_NOT_ON     = 2'd2;
  localparam logic [1:0] ST_DUP_LINK   = 2'd3;

  localparam logic [1:0] PU_LINK = 2'd0;
  localparam logic [1:0] PU_INC  = 2'd1;
  localparam logic [1:0] PU_DEC  = 2'd2;

  typedef struct packed {
    logic              en;
    logic [1:0]        mode;
    logic [PIDX_W-1:0] idx;
  } pu_cmd_t;

endpackage

// ===== hdl/pct_path_unit.sv =====
// Per-path edge totals, active counts and complete marks, with one shared
// update unit that reads and writes a single path per cycle.
// Depends on pct_pkg.
module pct_path_unit #(
  parameter int PATHS = pct_pkg::PATHS_DEF,
  parameter int CW    = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pct_pkg::pu_cmd_t cmd,
  input  logic             edge_active,
  output logic [CW-1:0]    rd_total,
  output logic [CW-1:0]    rd_count,
  output logic             rd_done,
  output logic             fresh
);
  import pct_pkg::*;

  localparam int PW = (PATHS > 1) ? $clog2(PATHS) : 1;

  logic [CW-1:0]    total_r [PATHS];
  logic [CW-1:0]    count_r [PATHS];
  logic [PATHS-1:0] done_r;
  logic [PW-1:0]    idx;
  logic [CW-1:0]    total_nxt;
  logic [CW-1:0]    count_nxt;
  logic             done_nxt;
  logic             fresh_c;

  assign idx      = cmd.idx[PW-1:0];
  assign rd_total = total_r[idx];
  assign rd_count = count_r[idx];
  assign rd_done  = done_r[idx];
  assign fresh    = cmd.en && fresh_c;

  always_comb begin
    total_nxt = rd_total;
    count_nxt = rd_count;
    done_nxt  = rd_done;
    fresh_c   = 1'b0;
    case (cmd.mode)
      PU_LINK: begin
        total_nxt = rd_total + CW'(1);
        count_nxt = rd_count + CW'(edge_active);
        done_nxt  = (count_nxt == total_nxt);
        fresh_c   = done_nxt && !rd_done;
      end
      PU_INC: begin
        count_nxt = rd_count + CW'(1);
        if (count_nxt == rd_total && !rd_done) begin
          done_nxt = 1'b1;
          fresh_c  = 1'b1;
        end
      end
      PU_DEC: begin
        if (rd_count != '0) begin
          count_nxt = rd_count - CW'(1);
        end
        done_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PATHS; i++) begin
        total_r[i] <= '0;
        count_r[i] <= '0;
      end
      done_r <= '0;
    end else if (cmd.en) begin
      total_r[idx] <= total_nxt;
      count_r[idx] <= count_nxt;
      done_r[idx]  <= done_nxt;
    end
  end

endmodule

// ===== hdl/path_completion_tracker.sv =====
// Path completion tracker top level: input sequencer, edge memory with link
// and active bits, output register. Depends on pct_pkg and pct_path_unit.
//
// Channels: in_* carries one command item (link, activate, deactivate, query);
// out_* returns exactly one result item per command, in order.
// After reset the edge memory is swept clean, one entry per cycle; in_tready stays
// low meanwhile.
// Link, query and flagged items reach the result register through these steps:
// accept with memory read, decode with memory write and counter update, finish.
// Activate and deactivate items that switch the edge add a sweep step after
// decode: the single path counter unit walks every path once, one path per cycle.
// The block holds one item at a time; in_tready is high only while idle, so a
// new item is taken only once the last one has left the finish step.
// A result waits in the output register while the receiver stalls; the next
// item is accepted meanwhile, and its result waits in the finish step until
// the register is free.
module path_completion_tracker #(
  parameter int EDGES = pct_pkg::EDGES_DEF,
  parameter int PATHS = pct_pkg::PATHS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // op[1:0], edge_req[9:2], path[14:10], zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // status[1:0], path_complete[2], active_edges[11:3],
                                  // total_edges[20:12], newly_complete[26:21], zero
);
  import pct_pkg::*;

  localparam int EW = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int PW = (PATHS > 1) ? $clog2(PATHS) : 1;
  localparam int CW = $clog2(EDGES + 1);
  localparam int FW = $clog2(PATHS + 1);
  localparam int MW = PATHS + 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    op_r;
  logic [7:0]    edge_r;
  logic [4:0]    path_r;
  logic [EW-1:0] clr_r, clr_nxt;
  logic [PW-1:0] idx_r, idx_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [FW-1:0] fresh_r, fresh_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_data_r, out_data_nxt;

  logic [MW-1:0] mem [EDGES];
  logic [MW-1:0] mem_rd_r;
  logic          mem_we;
  logic [EW-1:0] mem_wa;
  logic [MW-1:0] mem_wd;

  logic          in_fire;
  logic [EW+7:0] in_eext;
  logic [EW+7:0] eext;
  logic [EW-1:0] eaddr;
  logic          e_ok;
  logic [PW+4:0] pext;
  logic [PW-1:0] pidx;
  logic          p_ok;
  logic          edge_is_on;

  pu_cmd_t       cmd;
  logic [CW-1:0] rd_total, rd_count;
  logic          rd_done, fresh;
  logic [CW+8:0] cnt_ext, tot_ext;
  logic [FW+5:0] fresh_ext;
  logic [8:0]    act_sat, tot_sat;
  logic [5:0]    fresh_sat;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign in_eext    = (EW + 8)'(in_tdata[9:2]);
  assign eext       = (EW + 8)'(edge_r);
  assign eaddr      = eext[EW-1:0];
  assign e_ok       = eext < (EW + 8)'(EDGES);
  assign pext       = (PW + 5)'(path_r);
  assign pidx       = pext[PW-1:0];
  assign p_ok       = pext < (PW + 5)'(PATHS);
  assign edge_is_on = mem_rd_r[PATHS];

  pct_path_unit #(
    .PATHS(PATHS),
    .CW   (CW)
  ) u_path (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .edge_active(edge_is_on),
    .rd_total   (rd_total),
    .rd_count   (rd_count),
    .rd_done    (rd_done),
    .fresh      (fresh)
  );

  assign cnt_ext   = (CW + 9)'(rd_count);
  assign tot_ext   = (CW + 9)'(rd_total);
  assign act_sat   = (cnt_ext > (CW + 9)'(511)) ? 9'd511 : cnt_ext[8:0];
  assign tot_sat   = (tot_ext > (CW + 9)'(511)) ? 9'd511 : tot_ext[8:0];
  assign fresh_ext = (FW + 6)'(fresh_r);
  assign fresh_sat = (fresh_ext > (FW + 6)'(63)) ? 6'd63 : fresh_ext[5:0];

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    idx_nxt       = idx_r;
    status_nxt    = status_r;
    fresh_nxt     = fresh_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wa        = eaddr;
    mem_wd        = mem_rd_r;
    cmd.en        = 1'b0;
    cmd.mode      = PU_LINK;
    cmd.idx       = PIDX_W'(pidx);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = '0;
        if (clr_r == EW'(EDGES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + EW'(1);
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          status_nxt = ST_OK;
          fresh_nxt  = '0;
          idx_nxt    = '0;
          state_nxt  = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt = S_FIN;
        case (op_r)
          OP_LINK: begin
            if (e_ok && p_ok) begin
              if (mem_rd_r[pidx]) begin
                status_nxt = ST_DUP_LINK;
              end else begin
                mem_we    = 1'b1;
                mem_wd    = mem_rd_r | (MW'(1) << pidx);
                cmd.en    = 1'b1;
                cmd.mode  = PU_LINK;
                fresh_nxt = fresh_r + FW'(fresh);
              end
            end
          end
          OP_ON: begin
            if (e_ok) begin
              if (edge_is_on) begin
                status_nxt = ST_ALREADY_ON;
              end else begin
                mem_we            = 1'b1;
                mem_wd[PATHS]     = 1'b1;
                state_nxt         = S_SWEEP;
              end
            end
          end
          OP_OFF: begin
            if (e_ok) begin
              if (!edge_is_on) begin
                status_nxt = ST_NOT_ON;
              end else begin
                mem_we            = 1'b1;
                mem_wd[PATHS]     = 1'b0;
                state_nxt         = S_SWEEP;
              end
            end
          end
          default: ;
        endcase
      end
      S_SWEEP: begin
        cmd.en    = mem_rd_r[idx_r];
        cmd.mode  = (op_r == OP_ON) ? PU_INC : PU_DEC;
        cmd.idx   = PIDX_W'(idx_r);
        fresh_nxt = fresh_r + FW'(fresh);
        if (idx_r == PW'(PATHS - 1)) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_r + PW'(1);
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, fresh_sat,
                           p_ok ? tot_sat : 9'd0,
                           p_ok ? act_sat : 9'd0,
                           p_ok && rd_done,
                           status_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    status_r   <= status_nxt;
    fresh_r    <= fresh_nxt;
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      op_r   <= in_tdata[1:0];
      edge_r <= in_tdata[9:2];
      path_r <= in_tdata[14:10];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (in_fire) begin
      mem_rd_r <= mem[in_eext[EW-1:0]];
    end
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_LOOK)
    else $error("accepted item not decoded next cycle");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the finish step");

  a_error_no_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[1:0] != ST_OK |-> out_data_r[26:21] == 6'd0)
    else $error("flagged item reports newly complete paths");

  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (FW + 6)'(out_data_r[26:21]) <= (FW + 6)'(PATHS))
    else $error("newly complete count exceeds path count");

endmodule
